@@ rtl/edd_pkg.sv @@
// Shared types and register indexes for the error-diffusion dither block.
// Used by the pixel datapath, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package edd_pkg;

  // Configuration register indexes.
  localparam logic REG_LINE_WIDTH  = 1'b0;
  localparam logic REG_FRAME_LINES = 1'b1;

  // Gray or binary pixel, unsigned.
  typedef logic [7:0] pix_t;

  // Quantization error, two's complement, -127..127.
  typedef logic signed [7:0] err_t;

  // Which neighbor errors lie inside the current frame and may be applied.
  typedef struct packed {
    logic below_right;  // error from width+1 pixels back, weight 1/16
    logic below;        // error from width pixels back, weight 5/16
    logic below_left;   // error from width-1 pixels back, weight 3/16
    logic next;         // error from the previous pixel, weight 7/16
  } taps_t;

endpackage

@@ rtl/edd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the error history line; no package dependency.
`timescale 1ns / 1ps

module edd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4097
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/edd_quant.sv @@
// Pixel datapath: applies the four diffused error shares with clamping,
// thresholds the result and forms the new error. Depends on edd_pkg.
`timescale 1ns / 1ps

module edd_quant
  import edd_pkg::*;
(
  input  pix_t  gray,
  input  taps_t taps,
  input  err_t  err_next,         // previous pixel
  input  err_t  err_below_left,   // width-1 back
  input  err_t  err_below,        // width back
  input  err_t  err_below_right,  // width+1 back
  output pix_t  bin_pixel,
  output err_t  err
);

  localparam pix_t       THRESHOLD = 8'd127;
  localparam pix_t       PIX_WHITE = 8'd255;
  localparam pix_t       PIX_BLACK = 8'd0;
  localparam logic [3:0] WT_NEXT   = 4'd7;
  localparam logic [3:0] WT_BLEFT  = 4'd3;
  localparam logic [3:0] WT_BELOW  = 4'd5;
  localparam logic [3:0] WT_BRIGHT = 4'd1;

  // Weighted share of an error, divided by 16 and truncated toward zero.
  function automatic err_t share(err_t e, logic [3:0] wt);
    logic signed [12:0] prod;
    prod = 13'(e) * $signed({1'b0, wt});
    if (prod < 0) begin
      prod = prod + 13'sd15;
    end
    return err_t'(prod >>> 4);
  endfunction

  // Add a share to a pixel and saturate to 0..255.
  function automatic pix_t clamp_add(pix_t pix, err_t s);
    logic signed [9:0] t;
    t = $signed({2'b00, pix}) + 10'(s);
    if (t > 10'sd255) begin
      return PIX_WHITE;
    end else if (t < 10'sd0) begin
      return PIX_BLACK;
    end
    return t[7:0];
  endfunction

  pix_t v0, v1, v2, v3;

  // Shares are applied in the order the neighbors produced them.
  always_comb begin
    v0 = taps.below_right ? clamp_add(gray, share(err_below_right, WT_BRIGHT)) : gray;
    v1 = taps.below       ? clamp_add(v0, share(err_below, WT_BELOW))          : v0;
    v2 = taps.below_left  ? clamp_add(v1, share(err_below_left, WT_BLEFT))     : v1;
    v3 = taps.next        ? clamp_add(v2, share(err_next, WT_NEXT))            : v2;
  end

  // Threshold and residual error.
  always_comb begin
    if (v3 > THRESHOLD) begin
      bin_pixel = PIX_WHITE;
      err       = err_t'({1'b0, v3} - {1'b0, PIX_WHITE});
    end else begin
      bin_pixel = PIX_BLACK;
      err       = err_t'(v3);
    end
  end

endmodule

@@ rtl/error_diffusion_dither_core.sv @@
// Top level of the error-diffusion dither block.
// Depends on edd_pkg, edd_quant and edd_ram.
`timescale 1ns / 1ps
//
// Usage:
// - Input stream (in_*): one 8-bit gray pixel per request, raster order.
// - Output stream (out_*): one request per input pixel, tdata is 0 or 255,
//   tlast marks the last pixel of the frame (line_width x frame_lines).
// - Config port (cfg_*): index 0 is line_width, index 1 is frame_lines.
//   Write only while the block is idle. After each write the block
//   refetches the error line at the new width, with in_tready low.
// - An accepted pixel's result goes straight into the output register.
//   Throughput is one pixel per clock while in_tready is high; the loop that
//   sets it is the previous pixel's error feeding the next pixel's clamped add chain.
// - The error line is a MAX_WIDTH+1 entry RAM with one read and one write
//   per pixel; the three older neighbor errors come from a prefetch read
//   issued one pixel ahead and a two-register shift.
// - The output register lets a new pixel be taken in the same cycle that
//   the held result leaves; when out_tready is low and a result is held,
//   in_tready drops and nothing is lost.
// - Reset (rst_n low, synchronous) clears position counters, output valid
//   and config to 640 x 480. The RAM is not cleared; entries are only
//   used once the current frame has written them.

module error_diffusion_dither_core
  import edd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] gray_pixel
  // Output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_pixel
  output logic        out_tlast,  // frame_end
  // Configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);

  localparam logic [1:0] PRIME_CYCLES    = 2'd3;

  localparam logic [AW:0]   DEPTH_V = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] WR_LAST = AW'(DEPTH - 1);

  // Width minus one, with the width held to 3..MAX_WIDTH.
  function automatic logic [CW-1:0] width_m1(logic [12:0] lw);
    int v;
    v = int'(lw);
    if (v < 3) begin
      v = 3;
    end
    if (v > MAX_WIDTH) begin
      v = MAX_WIDTH;
    end
    return CW'(v - 1);
  endfunction

  // Row count minus one, zero rows count as one.
  function automatic logic [15:0] lines_m1(logic [15:0] fl);
    return (fl == 16'd0) ? 16'd0 : fl - 16'd1;
  endfunction

  logic [CW-1:0] w_m1_r;
  logic [15:0]   h_m1_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [AW-1:0] wr_r, wr_nxt;
  logic [1:0]    prime_cnt_r;
  err_t          e1_r, ew_r, ewp1_r;
  err_t          ram_rdata;
  logic          out_tvalid_r;
  pix_t          out_pixel_r;
  logic          out_last_r;

  logic          accept, priming, shift_en;
  logic          row_end, frame_end;
  taps_t         taps;
  pix_t          bin_pixel;
  err_t          err;
  logic [AW-1:0] rd_base;
  logic [1:0]    rd_back;
  logic [AW:0]   rd_sub, rd_tmp;
  logic [AW-1:0] rd_addr;

  assign priming   = (prime_cnt_r != 2'd0);
  assign in_tready = !priming && (!out_tvalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign shift_en  = accept || priming;

  // Configuration registers, stored already clamped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r <= width_m1(13'd640);
      h_m1_r <= lines_m1(16'd480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH:  w_m1_r <= width_m1(cfg_wdata[12:0]);
        REG_FRAME_LINES: h_m1_r <= lines_m1(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Refetch of the neighbor errors after a register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_cnt_r <= 2'd0;
    end else if (cfg_we) begin
      prime_cnt_r <= PRIME_CYCLES;
    end else if (priming) begin
      prime_cnt_r <= prime_cnt_r - 2'd1;
    end
  end

  // Which neighbors lie earlier in the current frame.
  always_comb begin
    taps.next        = (row_r != 16'd0) || (col_r != '0);
    taps.below_left  = (row_r != 16'd0) || (col_r >= w_m1_r);
    taps.below       = (row_r != 16'd0);
    taps.below_right = (row_r >= 16'd2) || ((row_r != 16'd0) && (col_r != '0));
  end

  edd_quant u_quant (
    .gray            (in_tdata),
    .taps            (taps),
    .err_next        (e1_r),
    .err_below_left  (ram_rdata),
    .err_below       (ew_r),
    .err_below_right (ewp1_r),
    .bin_pixel       (bin_pixel),
    .err             (err)
  );

  // Frame position and history write pointer.
  always_comb begin
    row_end   = (col_r >= w_m1_r);
    frame_end = row_end && (row_r >= h_m1_r);
    if (frame_end) begin
      col_nxt = '0;
      row_nxt = 16'd0;
      wr_nxt  = '0;
    end else begin
      wr_nxt = (wr_r == WR_LAST) ? '0 : wr_r + AW'(1);
      if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 16'd1;
      end else begin
        col_nxt = col_r + CW'(1);
        row_nxt = row_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 16'd0;
      wr_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      wr_r  <= wr_nxt;
    end
  end

  // Read address: (base - (width - 1) - back) modulo the line depth.
  // A pixel prefetches the next pixel's width-1 neighbor; a refetch
  // walks from width+1 back down to width-1 back.
  always_comb begin
    rd_base = accept ? wr_nxt : wr_r;
    rd_back = accept ? 2'd0 : prime_cnt_r - 2'd1;
    rd_sub  = (AW + 1)'(w_m1_r) + (AW + 1)'(rd_back);
    rd_tmp  = {1'b0, rd_base} + DEPTH_V - rd_sub;
    if (rd_tmp >= DEPTH_V) begin
      rd_addr = AW'(rd_tmp - DEPTH_V);
    end else begin
      rd_addr = rd_tmp[AW-1:0];
    end
  end

  edd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_r),
    .wdata (err),
    .re    (shift_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Older neighbor errors shift along as the read data advances.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      ewp1_r <= ew_r;
      ew_r   <= ram_rdata;
    end
    if (accept) begin
      e1_r <= err;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pixel_r <= bin_pixel;
      out_last_r  <= frame_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_last_r;

endmodule

@@ dv/tb_error_diffusion_dither_core.sv @@
// Self-checking testbench for error_diffusion_dither_core: streams gray pixels under
// several frame geometries and idle patterns and checks every binary pixel and frame
// end against an in-bench dither predictor. Depends on edd_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_error_diffusion_dither_core
  import edd_pkg::*;
();

  localparam int MAX_W = 4096;
  localparam int HIST_DEPTH = MAX_W + 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS = 1250;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    pix_t pixel;
    logic last;
  } dither_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  pix_t        in_tdata = '0;   // [7:0] gray_pixel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  pix_t        out_tdata;       // [7:0] out_pixel
  logic        out_tlast;       // frame_end
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  error_diffusion_dither_core #(
    .MAX_WIDTH(MAX_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and scoreboard storage.
  pix_t        gray_backlog[$];
  dither_out_t expected_px[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          in_fired = 1'b0;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;
  int          pixels_in = 0;
  int          frames_seen = 0;
  int          reg_writes = 0;
  int          random_sent = 0;

  // Long output hold-off, requested by toggling hold_trig.
  bit          hold_trig = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_len = 0;
  int          hold_left = 0;

  // Predictor state: error line, frame position and register copies.
  err_t        err_line[HIST_DEPTH];
  int          col_cnt = 0;
  int          row_cnt = 0;
  int          wr_ptr = 0;
  int          px_in_frame = 0;
  logic [12:0] cfg_width = 13'd640;
  logic [15:0] cfg_lines = 16'd480;

  // Width as the block uses it, clamped to the legal range.
  function automatic int eff_width(input logic [12:0] raw);
    if (raw < 3) return 3;
    if (raw > MAX_W) return MAX_W;
    return int'(raw);
  endfunction

  function automatic int past_err(input int back);
    return int'(err_line[(wr_ptr + HIST_DEPTH - back) % HIST_DEPTH]);
  endfunction

  function automatic int clamp_add(input int pix, input int share);
    int sum;
    sum = pix + share;
    if (sum > 255) return 255;
    if (sum < 0) return 0;
    return sum;
  endfunction

  // Dither one pixel: collect neighbor shares in production order, threshold,
  // store the new error and advance the frame position.
  function automatic dither_out_t dither_pixel(input pix_t gray);
    int          w, h, col, v, e;
    longint      pos;
    bit          row_end, frame_done;
    dither_out_t res;
    w = eff_width(cfg_width);
    h = (cfg_lines == 0) ? 1 : int'(cfg_lines);
    col = (col_cnt > w - 1) ? w - 1 : col_cnt;
    pos = longint'(row_cnt) * w + col;
    v = int'(gray);
    if (pos >= w + 1) v = clamp_add(v, past_err(w + 1) / 16);
    if (pos >= w)     v = clamp_add(v, (past_err(w) * 5) / 16);
    if (pos >= w - 1) v = clamp_add(v, (past_err(w - 1) * 3) / 16);
    if (pos >= 1)     v = clamp_add(v, (past_err(1) * 7) / 16);
    res.pixel = (v > 127) ? 8'd255 : 8'd0;
    e = v - int'(res.pixel);
    err_line[wr_ptr] = err_t'(e);
    wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    row_end = col_cnt >= w - 1;
    frame_done = row_end && (row_cnt >= h - 1);
    if (frame_done) begin
      col_cnt = 0;
      row_cnt = 0;
      wr_ptr = 0;
      px_in_frame = 0;
    end else begin
      px_in_frame++;
      if (row_end) begin
        col_cnt = 0;
        row_cnt++;
      end else begin
        col_cnt++;
      end
    end
    res.last = frame_done;
    return res;
  endfunction

  // A width change mid-frame must not move the position past the pixels
  // written in this frame, or the block would read error entries never written.
  function automatic bit width_write_safe(input logic [15:0] value);
    int w, col;
    w = eff_width(value[12:0]);
    col = (col_cnt > w - 1) ? w - 1 : col_cnt;
    return (longint'(row_cnt) * w + col) <= px_in_frame;
  endfunction

  function automatic logic [15:0] pick_width();
    int r, w;
    r = $urandom_range(99);
    if (r < 65) w = $urandom_range(12, 3);
    else if (r < 85) w = $urandom_range(80, 13);
    else if (r < 93) w = $urandom_range(2, 0);
    else w = $urandom_range(1) ? MAX_W : $urandom_range(8191, MAX_W + 1);
    // Bits above the register width are ignored by the block.
    return {3'($urandom_range(7)), 13'(w)};
  endfunction

  function automatic logic [15:0] pick_lines();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 65) return 16'($urandom_range(6, 1));
    if (r < 90) return 16'($urandom_range(40, 7));
    return 16'($urandom_range(65535));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH @%0t ns: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Input driver: a new pixel is offered once the previous request has gone.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fired) begin
      if (gray_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= gray_backlog.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_trig != hold_ack) begin
      hold_ack = hold_trig;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results, predict accepted pixels, and watch for a hang.
  always @(posedge clk) begin
    dither_out_t want;
    in_fired = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_px.size() == 0) begin
          report_mismatch("result with no pixel pending, out_pixel", out_tdata, -1);
        end else begin
          want = expected_px.pop_front();
          if (out_tdata !== want.pixel) report_mismatch("out_pixel", out_tdata, want.pixel);
          if (out_tlast !== want.last) report_mismatch("frame_end", out_tlast, want.last);
        end
        if (out_tlast === 1'b1) frames_seen++;
      end
      if (in_tvalid && in_tready) begin
        in_fired = 1'b1;
        expected_px.push_back(dither_pixel(in_tdata));
        pixels_in++;
      end
      if (in_fired || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Wait until every queued pixel is sent and every result has come back.
  // The check runs at the rising edge, where the sender state is settled,
  // and the task returns at the following falling edge.
  task automatic wait_drained();
    do @(posedge clk);
    while (gray_backlog.size() != 0 || in_tvalid || expected_px.size() != 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LINE_WIDTH) cfg_width = value[12:0];
    else cfg_lines = value;
    reg_writes++;
  endtask

  // One random phase: idle pattern, optional geometry change, then runs of
  // pixel content (noise, flat patches, near threshold, extremes, ramps).
  task automatic random_phase(input int mode, input bit long_hold);
    int          n, k, j, run, style;
    logic [15:0] width_val;
    pix_t        level, px;
    wait_drained();
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 63;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 63;
      end
      default: begin
        send_idle_pct = 7;
        recv_stall_pct = 7;
      end
    endcase
    if ($urandom_range(99) < 60) begin
      width_val = pick_width();
      if (width_write_safe(width_val)) write_reg(REG_LINE_WIDTH, width_val);
    end
    if ($urandom_range(99) < 50) write_reg(REG_FRAME_LINES, pick_lines());
    n = $urandom_range(110, 30);
    k = 0;
    while (k < n) begin
      run = $urandom_range(24, 4);
      style = $urandom_range(4);
      level = pix_t'($urandom_range(255));
      for (j = 0; j < run && k < n; j++) begin
        case (style)
          0: px = pix_t'($urandom_range(255));
          1: px = level;
          2: px = pix_t'($urandom_range(143, 112));
          3: px = $urandom_range(1) ? pix_t'($urandom_range(255, 247))
                                    : pix_t'($urandom_range(8));
          default: px = pix_t'(level + j * 9);
        endcase
        gray_backlog.push_back(px);
        k++;
      end
    end
    // Hold the output off while the sender keeps offering, so the block fills up.
    if (long_hold) begin
      hold_len = $urandom_range(300, 150);
      hold_trig = ~hold_trig;
    end
    random_sent += n;
  endtask

  initial begin
    int phase_no;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry (640 x 480), extremes and both sides of the threshold.
    gray_backlog.push_back(8'd0);
    gray_backlog.push_back(8'd255);
    gray_backlog.push_back(8'd127);
    gray_backlog.push_back(8'd128);

    // Shrink the width mid-row: the next pixel closes the row; two-row frame.
    write_reg(REG_LINE_WIDTH, 16'd3);
    write_reg(REG_FRAME_LINES, 16'd2);
    gray_backlog.push_back(8'd200);
    gray_backlog.push_back(8'd60);
    gray_backlog.push_back(8'd130);
    gray_backlog.push_back(8'd255);

    // Width below the legal range and zero lines: single three-pixel rows.
    write_reg(REG_LINE_WIDTH, 16'd0);
    write_reg(REG_FRAME_LINES, 16'd0);
    gray_backlog.push_back(8'd100);
    gray_backlog.push_back(8'd100);
    gray_backlog.push_back(8'd100);

    // All-ones writes: width clamps to the maximum, longest frame.
    write_reg(REG_LINE_WIDTH, 16'hFFFF);
    write_reg(REG_FRAME_LINES, 16'hFFFF);
    gray_backlog.push_back(8'd1);
    gray_backlog.push_back(8'd254);
    gray_backlog.push_back(8'd128);
    gray_backlog.push_back(8'd127);

    // Masked upper bits give width 4; the column is past the new row end.
    write_reg(REG_LINE_WIDTH, 16'h2004);
    write_reg(REG_FRAME_LINES, 16'd2);
    gray_backlog.push_back(8'd255);
    repeat (4) gray_backlog.push_back(8'd0);

    // Lines cut below the current row: the frame ends at this row's end.
    write_reg(REG_LINE_WIDTH, 16'd3);
    write_reg(REG_FRAME_LINES, 16'd4);
    gray_backlog.push_back(8'd30);
    gray_backlog.push_back(8'd220);
    gray_backlog.push_back(8'd90);
    gray_backlog.push_back(8'd170);
    write_reg(REG_FRAME_LINES, 16'd1);
    gray_backlog.push_back(8'd140);
    gray_backlog.push_back(8'd115);

    // Random phases cycling through the idle patterns.
    phase_no = 0;
    while (random_sent < RANDOM_PIXELS) begin
      random_phase(phase_no % 4, (phase_no % 5) == 2);
      phase_no++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Run covered %0d pixels, %0d completed frames and %0d register writes,",
             pixels_in, frames_seen, reg_writes);
    $display("including clamped widths, mid-frame geometry changes and long output stalls.");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches found", mismatch_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/edd_pkg.sv
rtl/edd_ram.sv
rtl/edd_quant.sv
rtl/error_diffusion_dither_core.sv
dv/tb_error_diffusion_dither_core.sv
